// ----- rtl/pfe_pkg.sv -----
// Shared types, character codes, status codes and sequencer states of the postfix evaluator.
package pfe_pkg;

  localparam int DATA_W = 32;
  localparam int SYM_W  = 8;
  localparam int STAT_W = 3;

  typedef logic [DATA_W-1:0] word_t;
  typedef logic [SYM_W-1:0]  sym_t;
  typedef logic [STAT_W-1:0] status_t;

  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_OVERFLOW  = 3'd1;
  localparam status_t ST_UNDERFLOW = 3'd2;
  localparam status_t ST_DIVZERO   = 3'd3;
  localparam status_t ST_INVALID   = 3'd4;

  localparam sym_t CH_0   = 8'h30;
  localparam sym_t CH_9   = 8'h39;
  localparam sym_t CH_ADD = 8'h2B;
  localparam sym_t CH_SUB = 8'h2D;
  localparam sym_t CH_MUL = 8'h2A;
  localparam sym_t CH_DIV = 8'h2F;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_RD_LHS,
    S_LD_LHS,
    S_CALC,
    S_DIV,
    S_WB,
    S_FIN,
    S_RD_TOP,
    S_EMIT
  } state_t;

endpackage

// ----- rtl/pfe_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pfe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/pfe_div.sv -----
// Iterative signed divider: one quotient bit a cycle, truncation toward zero.
module pfe_div import pfe_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  word_t dividend,
  input  word_t divisor,
  output logic  done,
  output word_t quotient
);

  localparam int CW = $clog2(DATA_W);

  logic              busy;
  logic              fix;
  logic [CW-1:0]     cnt;
  logic [DATA_W:0]   rem;
  word_t             quo;
  word_t             dvs;
  logic              neg;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   trial;

  assign shifted = {rem[DATA_W-1:0], quo[DATA_W-1]};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fix  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= fix;
      fix  <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == '0)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend[DATA_W-1] ? (word_t'(0) - dividend) : dividend;
      dvs <= divisor[DATA_W-1] ? (word_t'(0) - divisor) : divisor;
      neg <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
      rem <= '0;
      cnt <= CW'(DATA_W - 1);
    end else if (busy) begin
      // restore when the trial subtract goes negative
      if (!trial[DATA_W]) begin
        rem <= trial;
        quo <= {quo[DATA_W-2:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[DATA_W-2:0], 1'b0};
      end
      cnt <= cnt - CW'(1);
    end
    if (fix) begin
      quotient <= neg ? (word_t'(0) - quo) : quo;
    end
  end

endmodule

// ----- rtl/postfix_expression_evaluator_core.sv -----
// Postfix expression evaluator top level: sequencer, operand stack RAM and ALU.
//
// Takes one ASCII character per word on the item channel: a digit pushes 0-9, an
// operator + - * / pops two operands and pushes the 32-bit result (wrapping; division
// truncates toward zero). The word flagged last also emits the top of the stack and
// a sticky status (0 ok, 1 overflow, 2 underflow, 3 divide by zero, 4 invalid
// character) on the result channel, then clears the stack and status. Items are
// handled one at a time; the operand stack lives in a one-read-port RAM, so an
// operator reads its two operands in successive cycles. A digit or invalid character
// passes through S_EXEC and S_FIN; + - * also read both operands, compute and write
// back, and / waits in S_DIV on the 32-step restoring divider and its sign fixup. The
// last word then reads the top of a non-empty stack and loads the result; a waiting
// result does not block new items unless another result is ready to replace it.
module postfix_expression_evaluator_core import pfe_pkg::*; #(
  parameter int STACK_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  logic [SYM_W-1:0]    symbol,
  input  logic                last,
  output logic                result_valid,
  input  logic                result_ready,
  output logic signed [DATA_W-1:0] value,
  output logic [STAT_W-1:0]   status
);

  localparam int AW    = $clog2(STACK_DEPTH);
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  state_t            state;
  state_t            state_next;
  logic [CNT_W-1:0]  count;
  status_t           err;
  sym_t              sym_r;
  logic              last_r;
  word_t             lhs;
  word_t             rhs;
  word_t             res;
  word_t             top;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  word_t             ram_wdata;
  logic [AW-1:0]     ram_raddr;
  word_t             ram_rdata;

  logic              div_start;
  logic              div_done;
  word_t             div_q;

  logic              flag;
  status_t           flag_code;

  logic              is_digit;
  logic              is_op;
  logic              full;
  logic              short;
  logic              out_free;
  logic [CNT_W-1:0]  idx_m1;
  logic [CNT_W-1:0]  idx_m2;

  assign is_digit = sym_r inside {[CH_0:CH_9]};
  assign is_op    = sym_r inside {CH_ADD, CH_SUB, CH_MUL, CH_DIV};
  assign full     = (count == CNT_W'(STACK_DEPTH));
  assign short    = (count < CNT_W'(2));
  assign out_free = !result_valid || result_ready;
  assign idx_m1   = count - CNT_W'(1);
  assign idx_m2   = count - CNT_W'(2);

  pfe_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pfe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (lhs),
    .divisor  (rhs),
    .done     (div_done),
    .quotient (div_q)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (item_valid) state_next = S_EXEC;
      S_EXEC: begin
        if (is_op && !short) state_next = S_RD_LHS;
        else state_next = S_FIN;
      end
      S_RD_LHS: state_next = S_LD_LHS;
      S_LD_LHS: state_next = S_CALC;
      S_CALC: begin
        if (sym_r == CH_DIV) state_next = (rhs == '0) ? S_FIN : S_DIV;
        else state_next = S_WB;
      end
      S_DIV:    if (div_done) state_next = S_WB;
      S_WB:     state_next = S_FIN;
      S_FIN: begin
        if (!last_r) state_next = S_IDLE;
        else if (count == '0) state_next = S_EMIT;
        else state_next = S_RD_TOP;
      end
      S_RD_TOP: state_next = S_EMIT;
      S_EMIT:   if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    item_ready = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = count[AW-1:0];
    ram_wdata  = DATA_W'(sym_r - CH_0);
    ram_raddr  = idx_m1[AW-1:0];
    div_start  = 1'b0;
    flag       = 1'b0;
    flag_code  = ST_OK;
    case (state)
      S_IDLE: item_ready = 1'b1;
      S_EXEC: begin
        if (is_digit) begin
          if (full) begin
            flag      = 1'b1;
            flag_code = ST_OVERFLOW;
          end else begin
            ram_we = 1'b1;
          end
        end else if (!is_op) begin
          flag      = 1'b1;
          flag_code = ST_INVALID;
        end else if (short) begin
          flag      = 1'b1;
          flag_code = ST_UNDERFLOW;
        end
      end
      S_RD_LHS: ram_raddr = idx_m2[AW-1:0];
      S_CALC: begin
        if (sym_r == CH_DIV) begin
          if (rhs == '0) begin
            flag      = 1'b1;
            flag_code = ST_DIVZERO;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      S_WB: begin
        ram_we    = 1'b1;
        ram_waddr = idx_m2[AW-1:0];
        ram_wdata = res;
      end
      S_FIN: begin
        if (last_r && (count == '0)) begin
          flag      = 1'b1;
          flag_code = ST_UNDERFLOW;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      err          <= ST_OK;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (flag && (err == ST_OK)) begin
        err <= flag_code;
      end
      if (state == S_EXEC && is_digit && !full) begin
        count <= count + CNT_W'(1);
      end else if (state == S_WB) begin
        count <= idx_m1;
      end
      if (state == S_EMIT && out_free) begin
        result_valid <= 1'b1;
        count        <= '0;
        err          <= ST_OK;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      sym_r  <= symbol;
      last_r <= last;
    end
    if (state == S_RD_LHS) rhs <= ram_rdata;
    if (state == S_LD_LHS) lhs <= ram_rdata;
    case (state)
      S_CALC: begin
        if (sym_r == CH_ADD) res <= lhs + rhs;
        else if (sym_r == CH_SUB) res <= lhs - rhs;
        else res <= lhs * rhs;
      end
      S_DIV:    if (div_done) res <= div_q;
      S_FIN:    top <= '0;
      S_RD_TOP: top <= ram_rdata;
      default: ;
    endcase
    if (state == S_EMIT && out_free) begin
      value  <= top;
      status <= err;
    end
  end

  // both operands sit in their registers by S_CALC, where the divider takes them
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_clear_on_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> (count == '0) && (err == ST_OK))
    else $error("stack or status not cleared after result");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    div_start |-> (rhs != '0) && (sym_r == CH_DIV))
    else $error("divider started with zero divisor");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_free) |=> (status <= ST_INVALID) && result_valid)
    else $error("bad result status");

endmodule
